// ===== sv/pds_pkg.sv =====
// Package for the PLL divider search block: widths, limits, CSR indexes,
// controller states and the command/status structs.
// No dependencies.
`default_nettype none

package pds_pkg;

   localparam int FEEDBACK_MAX     = 320;
   localparam int FEEDBACK_MIN     = 16;
   localparam int POST_DIVIDER_MAX = 7;

   localparam int FB_W   = $clog2(FEEDBACK_MAX + 1);
   localparam int PD_W   = $clog2(POST_DIVIDER_MAX + 1);
   localparam int PROD_W = $clog2(POST_DIVIDER_MAX * POST_DIVIDER_MAX + 1);

   localparam int KHZ_W      = 20;
   localparam int REF_W      = 24;
   localparam int HZ_W       = 32;
   localparam int ERR_W      = 27;
   localparam int FB_OUT_W   = 9;
   localparam int PD_OUT_W   = 3;
   localparam int WANT_W     = KHZ_W + 10;
   localparam int VCO_W      = REF_W + FB_W;
   localparam int DIV_CNT_W  = $clog2(HZ_W + 1);

   localparam int HZ_PER_KHZ     = 1000;
   localparam int ERROR_BOUND_HZ = 100 * 1000 * 1000;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VCO_MIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VCO_MAX   = 2'd2;

   localparam logic [REF_W-1:0] REFERENCE_RESET = 24'd12000000;
   localparam logic [HZ_W-1:0]  VCO_MIN_RESET   = 32'd750000000;
   localparam logic [HZ_W-1:0]  VCO_MAX_RESET   = 32'd1600000000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WINDOW,
      ST_DSTART,
      ST_DIV,
      ST_EVAL,
      ST_NEXT,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic start;
      logic next_fb;
      logic div_go;
      logic eval;
      logic next_pair;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic win_ok;
      logic fb_last;
      logic pair_last;
      logic best_zero;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== sv/pds_req_if.sv =====
// Request channel: valid/ready handshake carrying the requested frequency.
// Depends on pds_pkg.
`default_nettype none

interface pds_req_if;
   import pds_pkg::*;

   logic             valid;
   logic             ready;
   logic [KHZ_W-1:0] required_khz;

   modport source (output valid, output required_khz, input ready);
   modport sink   (input valid, input required_khz, output ready);

endinterface

`default_nettype wire

// ===== sv/pds_rsp_if.sv =====
// Response channel: valid/ready handshake carrying the chosen PLL setting.
// Depends on pds_pkg.
`default_nettype none

interface pds_rsp_if;
   import pds_pkg::*;

   logic                valid;
   logic                ready;
   logic                found;
   logic [FB_OUT_W-1:0] feedback_divider;
   logic [PD_OUT_W-1:0] first_post_divider;
   logic [PD_OUT_W-1:0] second_post_divider;
   logic [HZ_W-1:0]     reached_hz;
   logic [ERR_W-1:0]    error_hz;

   modport source (output valid, output found, output feedback_divider,
                   output first_post_divider, output second_post_divider,
                   output reached_hz, output error_hz, input ready);
   modport sink   (input valid, input found, input feedback_divider,
                   input first_post_divider, input second_post_divider,
                   input reached_hz, input error_hz, output ready);

endinterface

`default_nettype wire

// ===== sv/pll_divider_search_top.sv =====
// Top level of the PLL divider search block: controller plus datapath.
// Depends on pds_pkg, pds_req_if, pds_rsp_if, pds_ctrl, pds_datapath.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+------------------------------------------
//   req_bus  | in  | valid/ready         | required_khz
//   rsp_bus  | out | valid/ready         | found, dividers, reached_hz, error_hz
//   csr_*    | in  | csr_we, no stall    | csr_index, csr_wdata
//
// Each item steps the feedback value down from the top and runs the divider once per
// in-window candidate pair, with up to 28 pairs per feedback value.
// One item is searched at a time; a new item is taken while a result waits.
// Reset loads the CSR defaults and empties the response register; no clearing pass.
// A stalled result holds in the response register; the next search then
// waits at its end until the register frees.
`default_nettype none

module pll_divider_search_top (
   input  wire                            clock,
   input  wire                            reset,
   pds_req_if.sink                        req_bus,
   pds_rsp_if.source                      rsp_bus,
   input  wire                            csr_we,
   input  wire [pds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [pds_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pds_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_bus.ready = req_ready;

   pds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pds_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .required_khz (req_bus.required_khz),
      .cmd          (cmd),
      .status       (status),
      .rsp_bus      (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== sv/pds_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on pds_pkg.
`default_nettype none

module pds_divider (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        go,
   input  wire [pds_pkg::HZ_W-1:0]    dividend,
   input  wire [pds_pkg::PROD_W-1:0]  divisor,
   output logic                       busy,
   output logic [pds_pkg::HZ_W-1:0]   quotient,
   output logic [pds_pkg::PROD_W-1:0] remainder
);
   import pds_pkg::*;

   logic [HZ_W-1:0]      quo_ff, quo_in;
   logic [PROD_W-1:0]    rem_ff, rem_in;
   logic [PROD_W-1:0]    dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W:0]      trial;
   logic [PROD_W:0]      diff;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[HZ_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      fits   = trial >= {1'b0, dsr_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (go) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = DIV_CNT_W'(HZ_W);
      end else if (cnt_ff != '0) begin
         quo_in = {quo_ff[HZ_W-2:0], fits};
         rem_in = fits ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== sv/pds_datapath.sv =====
// Datapath: CSRs, candidate counters, divider, best-candidate tracking and
// the response register. Depends on pds_pkg, pds_rsp_if, pds_divider.
`default_nettype none

module pds_datapath (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_we,
   input  wire [pds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [pds_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire [pds_pkg::KHZ_W-1:0]       required_khz,
   input  pds_pkg::cmd_type               cmd,
   output pds_pkg::status_type            status,
   pds_rsp_if.source                      rsp_bus
);
   import pds_pkg::*;

   logic [REF_W-1:0]  reference_ff, reference_in;
   logic [HZ_W-1:0]   vco_min_ff, vco_min_in;
   logic [HZ_W-1:0]   vco_max_ff, vco_max_in;
   logic [WANT_W-1:0] want_ff, want_in;
   logic [VCO_W-1:0]  vco_ff, vco_in;
   logic [FB_W-1:0]   fb_ff, fb_in;
   logic [PD_W-1:0]   p1_ff, p1_in;
   logic [PD_W-1:0]   p2_ff, p2_in;
   logic [ERR_W-1:0]  best_ff, best_in;
   logic              hit_ff, hit_in;
   logic [FB_W-1:0]   sel_fb_ff, sel_fb_in;
   logic [PD_W-1:0]   sel_p1_ff, sel_p1_in;
   logic [PD_W-1:0]   sel_p2_ff, sel_p2_in;
   logic [HZ_W-1:0]   reach_ff, reach_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff, found_in;
   logic [FB_OUT_W-1:0] out_fb_ff, out_fb_in;
   logic [PD_OUT_W-1:0] out_p1_ff, out_p1_in;
   logic [PD_OUT_W-1:0] out_p2_ff, out_p2_in;
   logic [HZ_W-1:0]     out_reach_ff, out_reach_in;
   logic [ERR_W-1:0]    out_err_ff, out_err_in;

   logic              div_busy;
   logic [HZ_W-1:0]   quotient;
   logic [PROD_W-1:0] remainder;
   logic [PROD_W-1:0] prod;
   logic [HZ_W-1:0]   want_hz;
   logic [HZ_W-1:0]   err;
   logic              better;

   assign prod = PROD_W'(p1_ff) * PROD_W'(p2_ff);

   pds_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .go        (cmd.div_go),
      .dividend  (vco_ff[HZ_W-1:0]),
      .divisor   (prod),
      .busy      (div_busy),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_comb begin
      want_hz = HZ_W'(want_ff);
      err     = (quotient >= want_hz) ? quotient - want_hz : want_hz - quotient;
      better  = (remainder == '0) && (err < HZ_W'(best_ff));
   end

   always_comb begin
      reference_in = reference_ff;
      vco_min_in   = vco_min_ff;
      vco_max_in   = vco_max_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_REFERENCE: reference_in = csr_wdata[REF_W-1:0];
            CSR_VCO_MIN:   vco_min_in   = csr_wdata[HZ_W-1:0];
            CSR_VCO_MAX:   vco_max_in   = csr_wdata[HZ_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      want_in   = want_ff;
      vco_in    = vco_ff;
      fb_in     = fb_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      best_in   = best_ff;
      hit_in    = hit_ff;
      sel_fb_in = sel_fb_ff;
      sel_p1_in = sel_p1_ff;
      sel_p2_in = sel_p2_ff;
      reach_in  = reach_ff;
      if (cmd.start) begin
         want_in = WANT_W'(required_khz) * WANT_W'(HZ_PER_KHZ);
         vco_in  = VCO_W'(reference_ff) * VCO_W'(FEEDBACK_MAX);
         fb_in   = FB_W'(FEEDBACK_MAX);
         p1_in   = PD_W'(POST_DIVIDER_MAX);
         p2_in   = PD_W'(POST_DIVIDER_MAX);
         best_in = ERR_W'(ERROR_BOUND_HZ);
         hit_in  = 1'b0;
      end
      if (cmd.next_fb) begin
         vco_in = vco_ff - VCO_W'(reference_ff);
         fb_in  = fb_ff - 1'b1;
         p1_in  = PD_W'(POST_DIVIDER_MAX);
         p2_in  = PD_W'(POST_DIVIDER_MAX);
      end
      if (cmd.next_pair) begin
         if (p2_ff == PD_W'(1)) begin
            p1_in = p1_ff - 1'b1;
            p2_in = p1_ff - 1'b1;
         end else begin
            p2_in = p2_ff - 1'b1;
         end
      end
      if (cmd.eval && better) begin
         best_in   = err[ERR_W-1:0];
         hit_in    = 1'b1;
         sel_fb_in = fb_ff;
         sel_p1_in = p1_ff;
         sel_p2_in = p2_ff;
         reach_in  = quotient;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      out_fb_in    = out_fb_ff;
      out_p1_in    = out_p1_ff;
      out_p2_in    = out_p2_ff;
      out_reach_in = out_reach_ff;
      out_err_in   = out_err_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         found_in     = hit_ff;
         out_fb_in    = hit_ff ? FB_OUT_W'(sel_fb_ff) : '0;
         out_p1_in    = hit_ff ? PD_OUT_W'(sel_p1_ff) : '0;
         out_p2_in    = hit_ff ? PD_OUT_W'(sel_p2_ff) : '0;
         out_reach_in = hit_ff ? reach_ff : '0;
         out_err_in   = hit_ff ? best_ff : '0;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_ff <= REFERENCE_RESET;
         vco_min_ff   <= VCO_MIN_RESET;
         vco_max_ff   <= VCO_MAX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         reference_ff <= reference_in;
         vco_min_ff   <= vco_min_in;
         vco_max_ff   <= vco_max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      want_ff      <= want_in;
      vco_ff       <= vco_in;
      fb_ff        <= fb_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      best_ff      <= best_in;
      hit_ff       <= hit_in;
      sel_fb_ff    <= sel_fb_in;
      sel_p1_ff    <= sel_p1_in;
      sel_p2_ff    <= sel_p2_in;
      reach_ff     <= reach_in;
      found_ff     <= found_in;
      out_fb_ff    <= out_fb_in;
      out_p1_ff    <= out_p1_in;
      out_p2_ff    <= out_p2_in;
      out_reach_ff <= out_reach_in;
      out_err_ff   <= out_err_in;
   end

   always_comb begin
      status.win_ok    = (vco_ff >= VCO_W'(vco_min_ff)) && (vco_ff <= VCO_W'(vco_max_ff));
      status.fb_last   = fb_ff == FB_W'(FEEDBACK_MIN);
      status.pair_last = p1_ff == PD_W'(1);
      status.best_zero = best_ff == '0;
      status.div_busy  = div_busy;
      status.out_free  = !rsp_valid_ff || rsp_bus.ready;
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.found               = found_ff;
   assign rsp_bus.feedback_divider    = out_fb_ff;
   assign rsp_bus.first_post_divider  = out_p1_ff;
   assign rsp_bus.second_post_divider = out_p2_ff;
   assign rsp_bus.reached_hz          = out_reach_ff;
   assign rsp_bus.error_hz            = out_err_ff;

endmodule

`default_nettype wire

// ===== sv/pds_ctrl.sv =====
// Search controller: walks feedback and post divider candidates and
// sequences the divider. Depends on pds_pkg.
`default_nettype none

module pds_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  pds_pkg::status_type  status,
   output pds_pkg::cmd_type     cmd
);
   import pds_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_WINDOW;
            end
         end
         ST_WINDOW: begin
            priority if (status.win_ok) begin
               state_in = ST_DSTART;
            end else if (status.fb_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.next_fb = 1'b1;
            end
         end
         ST_DSTART: begin
            cmd.div_go = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            priority if (status.best_zero || (status.pair_last && status.fb_last)) begin
               state_in = ST_FINISH;
            end else if (status.pair_last) begin
               cmd.next_fb = 1'b1;
               state_in    = ST_WINDOW;
            end else begin
               cmd.next_pair = 1'b1;
               state_in      = ST_DSTART;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/pds_checker.sv =====
// Port-level checks for the PLL divider search block, bound to the top level.
// Depends on pds_pkg and pll_divider_search_top.
`default_nettype none

module pds_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             rsp_valid,
   input wire                             rsp_ready,
   input wire                             found,
   input wire [pds_pkg::FB_OUT_W-1:0]     feedback_divider,
   input wire [pds_pkg::PD_OUT_W-1:0]     first_post_divider,
   input wire [pds_pkg::PD_OUT_W-1:0]     second_post_divider,
   input wire [pds_pkg::HZ_W-1:0]         reached_hz,
   input wire [pds_pkg::ERR_W-1:0]        error_hz
);
   import pds_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(error_hz) && $stable(found))
      else $error("response item changed while stalled");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !found |-> feedback_divider == '0 && first_post_divider == '0 &&
      second_post_divider == '0 && reached_hz == '0 && error_hz == '0)
      else $error("fields not cleared when no setting found");

   a_found_dividers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && found |-> second_post_divider != '0 &&
      second_post_divider <= first_post_divider &&
      feedback_divider >= FB_OUT_W'(FEEDBACK_MIN) &&
      feedback_divider <= FB_OUT_W'(FEEDBACK_MAX))
      else $error("chosen dividers out of range");

   a_found_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && found |-> error_hz < ERR_W'(ERROR_BOUND_HZ))
      else $error("error not below bound");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind pll_divider_search_top pds_checker u_pds_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .found               (rsp_bus.found),
   .feedback_divider    (rsp_bus.feedback_divider),
   .first_post_divider  (rsp_bus.first_post_divider),
   .second_post_divider (rsp_bus.second_post_divider),
   .reached_hz          (rsp_bus.reached_hz),
   .error_hz            (rsp_bus.error_hz)
);

`default_nettype wire
